// File: src/vms_pkg.sv
`default_nettype none

package vms_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned SumW   = 2 * DiffW;
  localparam int unsigned RootW  = 34;
  localparam int unsigned RemW   = RootW + 1;
  localparam int unsigned Lanes  = 3;

  typedef struct packed {
    logic [Lanes-1:0][DiffW-1:0] mag;
    logic [Lanes-1:0]            dneg;
    logic [CoordW-1:0]           spd_mag;
    logic                        spd_neg;
    logic                        zero;
  } vms_ctx_t;

endpackage

`default_nettype wire

// File: src/vms_in_if.sv
`default_nettype none

interface vms_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [vms_pkg::CoordW-1:0] cur_x;
  logic signed [vms_pkg::CoordW-1:0] cur_y;
  logic signed [vms_pkg::CoordW-1:0] cur_z;
  logic signed [vms_pkg::CoordW-1:0] tgt_x;
  logic signed [vms_pkg::CoordW-1:0] tgt_y;
  logic signed [vms_pkg::CoordW-1:0] tgt_z;
  logic signed [vms_pkg::CoordW-1:0] step_speed;

  modport source (
    output valid, cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z, step_speed,
    input  ready
  );
  modport sink (
    input  valid, cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z, step_speed,
    output ready
  );
endinterface

`default_nettype wire

// File: src/vms_out_if.sv
`default_nettype none

interface vms_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [vms_pkg::CoordW-1:0] step_x;
  logic signed [vms_pkg::CoordW-1:0] step_y;
  logic signed [vms_pkg::CoordW-1:0] step_z;
  logic                      zero_length;
  logic                      saturated;

  modport source (
    output valid, step_x, step_y, step_z, zero_length, saturated,
    input  ready
  );
  modport sink (
    input  valid, step_x, step_y, step_z, zero_length, saturated,
    output ready
  );
endinterface

`default_nettype wire

// File: src/vms_sqrt_cell.sv
`default_nettype none

module vms_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  vms_pkg::vms_ctx_t           ctx_i,
  input  logic [vms_pkg::SumW-1:0]    rem_i,
  input  logic [vms_pkg::RootW-1:0]   root_i,
  output logic                        vld_o,
  output vms_pkg::vms_ctx_t           ctx_o,
  output logic [vms_pkg::SumW-1:0]    rem_o,
  output logic [vms_pkg::RootW-1:0]   root_o
);

  localparam int unsigned TrialW = 2 * vms_pkg::RootW + 1;

  logic [TrialW-1:0]         trial;
  logic [TrialW-1:0]         rem_x;
  logic                      fits;
  logic [vms_pkg::SumW-1:0]  rem_d, rem_q;
  logic [vms_pkg::RootW-1:0] root_d, root_q;
  vms_pkg::vms_ctx_t         ctx_q;
  logic                      vld_q;

  // (2r + 2^b) * 2^b is what setting bit b adds to the square
  always_comb begin
    trial = (TrialW'(root_i) << (BIT + 1)) + (TrialW'(1) << (2 * BIT));
    rem_x = TrialW'(rem_i);
    fits  = trial <= rem_x;
    root_d = root_i;
    if (fits) begin
      rem_d       = rem_x[vms_pkg::SumW-1:0] - trial[vms_pkg::SumW-1:0];
      root_d[BIT] = 1'b1;
    end else begin
      rem_d = rem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q  <= ctx_i;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign vld_o  = vld_q;
  assign ctx_o  = ctx_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// File: src/vms_div_cell.sv
`default_nettype none

module vms_div_cell #(
  parameter int unsigned QW    = 17,
  parameter bit          FIRST = 1'b0
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        vld_i,
  input  vms_pkg::vms_ctx_t                           ctx_i,
  input  logic [vms_pkg::RootW-1:0]                   len_i,
  input  logic [vms_pkg::Lanes-1:0][vms_pkg::RemW-1:0] rem_i,
  input  logic [vms_pkg::Lanes-1:0][QW-1:0]           quo_i,
  output logic                                        vld_o,
  output vms_pkg::vms_ctx_t                           ctx_o,
  output logic [vms_pkg::RootW-1:0]                   len_o,
  output logic [vms_pkg::Lanes-1:0][vms_pkg::RemW-1:0] rem_o,
  output logic [vms_pkg::Lanes-1:0][QW-1:0]           quo_o
);

  logic [vms_pkg::Lanes-1:0][vms_pkg::RemW-1:0] shf;
  logic [vms_pkg::Lanes-1:0]                    ge;
  logic [vms_pkg::Lanes-1:0][vms_pkg::RemW-1:0] rem_d, rem_q;
  logic [vms_pkg::Lanes-1:0][QW-1:0]            quo_d, quo_q;
  logic [vms_pkg::RootW-1:0]                    len_q;
  vms_pkg::vms_ctx_t                            ctx_q;
  logic                                         vld_q;

  always_comb begin
    for (int l = 0; l < vms_pkg::Lanes; l++) begin
      shf[l]   = FIRST ? rem_i[l] : (rem_i[l] << 1);
      ge[l]    = shf[l] >= vms_pkg::RemW'(len_i);
      rem_d[l] = ge[l] ? (shf[l] - vms_pkg::RemW'(len_i)) : shf[l];
      quo_d[l] = {quo_i[l][QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q <= ctx_i;
      len_q <= len_i;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign vld_o = vld_q;
  assign ctx_o = ctx_q;
  assign len_o = len_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

`default_nettype wire

// File: src/vector_move_step.sv
// Moves one step from a current point towards a target point: the difference vector is
// divided by its Euclidean length and scaled by the speed, all signed fixed point with
// FRAC_BITS fraction bits, each component saturated to 32 bits. A new word is taken every
// cycle while the output side keeps up. The pipeline is the 34-cell square root chain
// and the FRAC_BITS + 1 cell divider chain, plus five registered stages for difference,
// squares, sum, speed multiply and output. A stalled output holds the whole pipeline.
`default_nettype none

module vector_move_step #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vms_in_if.sink       in_i,
  vms_out_if.source    out_o
);

  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned ProdW = QW + vms_pkg::CoordW;
  localparam int unsigned SmW   = ProdW - FRAC_BITS;
  localparam int unsigned CW    = vms_pkg::CoordW;
  localparam int unsigned DW    = vms_pkg::DiffW;
  localparam int unsigned NL    = vms_pkg::Lanes;
  localparam int unsigned RW    = vms_pkg::RootW;

  logic en;

  // difference stage
  logic signed [CW-1:0] cur [NL];
  logic signed [CW-1:0] tgt [NL];
  logic signed [DW-1:0] dif [NL];
  vms_pkg::vms_ctx_t    a_d, a_q;
  logic                 a_vld_q;

  // square and sum stages
  logic [NL-1:0][vms_pkg::SumW-1:0] sq_d, sq_q;
  vms_pkg::vms_ctx_t                b_q, c_q;
  logic                             b_vld_q, c_vld_q;
  logic [vms_pkg::SumW-1:0]         sum_q;

  // root chain
  logic                     s_vld  [RW+1];
  vms_pkg::vms_ctx_t        s_ctx  [RW+1];
  logic [vms_pkg::SumW-1:0] s_rem  [RW+1];
  logic [RW-1:0]            s_root [RW+1];

  // divider chain
  logic                               v_vld [QW+1];
  vms_pkg::vms_ctx_t                  v_ctx [QW+1];
  logic [RW-1:0]                      v_len [QW+1];
  logic [NL-1:0][vms_pkg::RemW-1:0]   v_rem [QW+1];
  logic [NL-1:0][QW-1:0]              v_quo [QW+1];

  // multiply and output stages
  logic [NL-1:0][ProdW-1:0] prod_d, prod_q;
  vms_pkg::vms_ctx_t        m_q;
  logic                     m_vld_q;
  logic [SmW-1:0]           sm [NL];
  logic [NL-1:0][CW-1:0]    step_d, step_q;
  logic [NL-1:0]            clip;
  logic                     sat_d, sat_q, zero_q, o_vld_q;

  assign en        = !o_vld_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    cur[0] = in_i.cur_x;
    cur[1] = in_i.cur_y;
    cur[2] = in_i.cur_z;
    tgt[0] = in_i.tgt_x;
    tgt[1] = in_i.tgt_y;
    tgt[2] = in_i.tgt_z;
    for (int l = 0; l < NL; l++) begin
      dif[l]       = DW'(tgt[l]) - DW'(cur[l]);
      a_d.dneg[l]  = dif[l][DW-1];
      a_d.mag[l]   = dif[l][DW-1] ? DW'(-dif[l]) : DW'(dif[l]);
    end
    a_d.spd_neg = in_i.step_speed[CW-1];
    a_d.spd_mag = in_i.step_speed[CW-1] ? CW'(-in_i.step_speed) : CW'(in_i.step_speed);
    a_d.zero    = (a_d.mag[0] == '0) && (a_d.mag[1] == '0) && (a_d.mag[2] == '0);
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      sq_d[l] = vms_pkg::SumW'(a_q.mag[l]) * vms_pkg::SumW'(a_q.mag[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_i.valid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= a_d;
      b_q   <= a_q;
      sq_q  <= sq_d;
      c_q   <= b_q;
      sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  assign s_vld[0]  = c_vld_q;
  assign s_ctx[0]  = c_q;
  assign s_rem[0]  = sum_q;
  assign s_root[0] = '0;

  for (genvar k = 0; k < RW; k++) begin : g_root
    vms_sqrt_cell #(
      .BIT (RW - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (s_vld[k]),
      .ctx_i  (s_ctx[k]),
      .rem_i  (s_rem[k]),
      .root_i (s_root[k]),
      .vld_o  (s_vld[k+1]),
      .ctx_o  (s_ctx[k+1]),
      .rem_o  (s_rem[k+1]),
      .root_o (s_root[k+1])
    );
  end

  assign v_vld[0] = s_vld[RW];
  assign v_ctx[0] = s_ctx[RW];
  assign v_len[0] = s_root[RW];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      v_rem[0][l] = vms_pkg::RemW'(s_ctx[RW].mag[l]);
      v_quo[0][l] = '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    vms_div_cell #(
      .QW    (QW),
      .FIRST (k == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (v_vld[k]),
      .ctx_i  (v_ctx[k]),
      .len_i  (v_len[k]),
      .rem_i  (v_rem[k]),
      .quo_i  (v_quo[k]),
      .vld_o  (v_vld[k+1]),
      .ctx_o  (v_ctx[k+1]),
      .len_o  (v_len[k+1]),
      .rem_o  (v_rem[k+1]),
      .quo_o  (v_quo[k+1])
    );
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      prod_d[l] = ProdW'(v_quo[QW][l]) * ProdW'(v_ctx[QW].spd_mag);
    end
  end

  always_comb begin
    sat_d = 1'b0;
    for (int l = 0; l < NL; l++) begin
      sm[l] = prod_q[l][ProdW-1:FRAC_BITS];
      if ((m_q.dneg[l] != m_q.spd_neg) && (sm[l] != '0)) begin
        clip[l] = sm[l] > SmW'(33'h0_8000_0000);
        step_d[l] = clip[l] ? CW'(32'h8000_0000) : CW'(SmW'(0) - sm[l]);
      end else begin
        clip[l] = sm[l] > SmW'(33'h0_7FFF_FFFF);
        step_d[l] = clip[l] ? CW'(32'h7FFF_FFFF) : sm[l][CW-1:0];
      end
      if (m_q.zero) begin
        clip[l]   = 1'b0;
        step_d[l] = '0;
      end
      sat_d = sat_d | clip[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= v_vld[QW];
      o_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q    <= v_ctx[QW];
      prod_q <= prod_d;
      step_q <= step_d;
      sat_q  <= sat_d;
      zero_q <= m_q.zero;
    end
  end

  assign out_o.valid       = o_vld_q;
  assign out_o.step_x      = step_q[0];
  assign out_o.step_y      = step_q[1];
  assign out_o.step_z      = step_q[2];
  assign out_o.zero_length = zero_q;
  assign out_o.saturated   = sat_q;

  a_zero_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_length |->
      out_o.step_x == '0 && out_o.step_y == '0 && out_o.step_z == '0 && !out_o.saturated)
    else $error("zero length word carries a nonzero step");

  a_sat_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      out_o.step_x == 32'sh7FFF_FFFF || out_o.step_y == 32'sh7FFF_FFFF ||
      out_o.step_z == 32'sh7FFF_FFFF || out_o.step_x == 32'sh8000_0000 ||
      out_o.step_y == 32'sh8000_0000 || out_o.step_z == 32'sh8000_0000)
    else $error("saturated flag without a clamped component");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while output stalled");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits = 16;
  localparam int unsigned Latency = FracBits + 40;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned NumRandom = 500;

  typedef struct packed {
    logic signed [vms_pkg::CoordW-1:0] cx, cy, cz, tx, ty, tz, spd;
  } move_req_t;

  typedef struct packed {
    logic signed [vms_pkg::CoordW-1:0] sx, sy, sz;
    logic zero_len;
    logic sat;
  } move_step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  vms_in_if in_i();
  vms_out_if out_o();

  vector_move_step #(.FRAC_BITS(FracBits)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_i),
    .out_o(out_o)
  );

  move_req_t pending_q[$];
  move_step_t step_q[$];
  int unsigned errors = 0;
  int unsigned steps_seen = 0;
  int unsigned zero_seen = 0;
  int unsigned sat_seen = 0;
  int unsigned idle_cnt = 0;
  bit gaps_on = 1'b1;
  bit hold_src = 1'b0;
  bit timed_out = 1'b0;

  function automatic logic [33:0] isqrt68(logic [67:0] s);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({34'd0, c} * {34'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic move_step_t predict_step(move_req_t q);
    move_step_t res;
    logic signed [vms_pkg::CoordW:0] d[3];
    logic [vms_pkg::CoordW:0] dm[3];
    logic [67:0] sum;
    logic [33:0] len;
    logic [vms_pkg::CoordW-1:0] spm;
    logic [63:0] um;
    logic [127:0] sm;
    logic [vms_pkg::CoordW-1:0] comp[3];
    bit neg;
    d[0] = $signed({q.tx[31], q.tx}) - $signed({q.cx[31], q.cx});
    d[1] = $signed({q.ty[31], q.ty}) - $signed({q.cy[31], q.cy});
    d[2] = $signed({q.tz[31], q.tz}) - $signed({q.cz[31], q.cz});
    spm = q.spd[31] ? -q.spd : q.spd;
    sum = '0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      dm[i] = d[i][32] ? -d[i] : d[i];
      sum += {35'd0, dm[i]} * {35'd0, dm[i]};
    end
    if (sum == 0) begin
      res.zero_len = 1'b1;
      return res;
    end
    len = isqrt68(sum);
    for (int i = 0; i < 3; i++) begin
      um = ({31'd0, dm[i]} << FracBits) / {30'd0, len};
      sm = ({64'd0, um} * {96'd0, spm}) >> FracBits;
      neg = (d[i][32] != q.spd[31]) && sm != 0;
      if (neg) begin
        if (sm > 128'h8000_0000) begin
          sm = 128'h8000_0000;
          res.sat = 1'b1;
        end
        comp[i] = -sm[31:0];
      end else begin
        if (sm > 128'h7FFF_FFFF) begin
          sm = 128'h7FFF_FFFF;
          res.sat = 1'b1;
        end
        comp[i] = sm[31:0];
      end
    end
    res.sx = comp[0];
    res.sy = comp[1];
    res.sz = comp[2];
    return res;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 2047) - 1024;
      3: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_i.valid <= 1'b0;
      {in_i.cur_x, in_i.cur_y, in_i.cur_z} <= '0;
      {in_i.tgt_x, in_i.tgt_y, in_i.tgt_z, in_i.step_speed} <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        step_q.push_back(predict_step(pending_q.pop_front()));
      end
      if (in_i.valid && !in_i.ready) begin
        in_i.valid <= 1'b1;
      end else if (pending_q.size() > 0 && !hold_src &&
          !(gaps_on && $urandom_range(0, 99) < 24)) begin
        in_i.valid <= 1'b1;
        in_i.cur_x <= pending_q[0].cx;
        in_i.cur_y <= pending_q[0].cy;
        in_i.cur_z <= pending_q[0].cz;
        in_i.tgt_x <= pending_q[0].tx;
        in_i.tgt_y <= pending_q[0].ty;
        in_i.tgt_z <= pending_q[0].tz;
        in_i.step_speed <= pending_q[0].spd;
      end else begin
        in_i.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    move_step_t got;
    move_step_t want;
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
    end else begin
      out_o.ready <= !(gaps_on && $urandom_range(0, 99) < 24);
      if (out_o.valid && out_o.ready) begin
        got = {out_o.step_x, out_o.step_y, out_o.step_z, out_o.zero_length, out_o.saturated};
        steps_seen++;
        zero_seen += got.zero_len;
        sat_seen += got.sat;
        if (step_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: %p", got);
        end else begin
          want = step_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (idle_cnt >= WatchLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    move_req_t q;
    logic [31:0] ext[4];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: equal points, extremes, most negative speed
    q = '{32'h1234_5678, 32'h8000_0000, 32'h0, 32'h1234_5678, 32'h8000_0000, 32'h0,
          32'h0001_0000};
    pending_q.push_back(q);
    q = '0;
    pending_q.push_back(q);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        q = '{ext[i], ext[j], ext[3-i], ext[j], ext[i], ext[i], ext[(i+j)%4]};
        pending_q.push_back(q);
      end
    end
    q = '{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h8000_0000};
    pending_q.push_back(q);
    q = '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000};
    pending_q.push_back(q);
    q = '{32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF};
    pending_q.push_back(q);
    q = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h8000_0000};
    pending_q.push_back(q);
    q = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000};
    pending_q.push_back(q);
    wait (pending_q.size() == 0);
    // hold off until the pipeline drains
    hold_src = 1'b1;
    wait (step_q.size() == 0);
    hold_src = 1'b0;
    for (int n = 0; n < NumRandom; n++) begin
      q.cx = rand_coord();
      q.cy = rand_coord();
      q.cz = rand_coord();
      if ($urandom_range(0, 19) == 0) begin
        q.tx = q.cx;
        q.ty = q.cy;
        q.tz = q.cz;
      end else begin
        q.tx = rand_coord();
        q.ty = rand_coord();
        q.tz = rand_coord();
      end
      q.spd = rand_coord();
      pending_q.push_back(q);
      if (n == 200) begin
        wait (pending_q.size() == 0);
        gaps_on = 1'b0;
      end
      if (n == 350) begin
        wait (pending_q.size() == 0);
        gaps_on = 1'b1;
      end
    end
    wait (pending_q.size() == 0 && step_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    $display("checked %0d step words, %0d with zero length, %0d saturated",
             steps_seen, zero_seen, sat_seen);
    if (errors == 0 && step_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
